### hdl/srr_pkg.sv
// Package for the selective repeat receiver: fixed word widths,
// the acknowledgement fill value and the cell control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package srr_pkg;

  localparam int SEQ_W = 16;
  localparam int PAY_W = 64;
  localparam int ACK_W = 17;

  // ack_num when nothing has been acknowledged yet (-1)
  localparam logic [ACK_W-1:0] ACK_NONE = {ACK_W{1'b1}};

  typedef struct packed {
    logic wr;     // store the incoming payload
    logic shift;  // take the neighbor's contents
  } cell_ctrl_t;

endpackage
`default_nettype wire

### hdl/srr_in_if.sv
// Packet channel: valid/ready handshake with checksum flag, number and payload.
// Depends on srr_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface srr_in_if
  import srr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             checksum_ok;
  logic [SEQ_W-1:0] seq_num;
  logic [PAY_W-1:0] payload;

  modport source(output valid, checksum_ok, seq_num, payload, input ready);
  modport sink(input valid, checksum_ok, seq_num, payload, output ready);
endinterface
`default_nettype wire

### hdl/srr_out_if.sv
// Result channel: valid/ready handshake with delivery or acknowledgement word.
// Depends on srr_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface srr_out_if
  import srr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic        [PAY_W-1:0] data;
  logic signed [ACK_W-1:0] ack_num;
  logic                    last;

  modport source(output valid, kind, data, ack_num, last, input ready);
  modport sink(input valid, kind, data, ack_num, last, output ready);
endinterface
`default_nettype wire

### hdl/srr_cell.sv
// One window slot: received flag and payload word, shifted from its upper
// neighbor when the window slides. Depends on srr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srr_cell
  import srr_pkg::*;
#(
  parameter int PAYLOAD_BITS = 64
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire  cell_ctrl_t        ctrl,
  input  wire  [PAYLOAD_BITS-1:0] wr_data,
  input  wire                     nb_rcv,
  input  wire  [PAYLOAD_BITS-1:0] nb_pay,
  output logic                    rcv,
  output logic [PAYLOAD_BITS-1:0] pay
);

  logic                    rcv_r;
  logic [PAYLOAD_BITS-1:0] pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcv_r <= 1'b0;
    end else if (ctrl.shift) begin
      rcv_r <= nb_rcv;
    end else if (ctrl.wr) begin
      rcv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      pay_r <= nb_pay;
    end else if (ctrl.wr) begin
      pay_r <= wr_data;
    end
  end

  assign rcv = rcv_r;
  assign pay = pay_r;

endmodule
`default_nettype wire

### hdl/selective_repeat_receiver_top.sv
// Selective repeat receiver: a row of WINDOW slot cells, window base and
// acknowledgement state. Depends on srr_pkg, srr_in_if, srr_out_if, srr_cell.
// A packet is taken only while idle; its deliveries follow one word a cycle
// while the result side is ready, then the acknowledgement; no new packet is
// taken before that is accepted. A packet brings 0..WINDOW deliveries, the cell
// row moving one slot per delivered word. Synchronous active-low reset clears the
// base, received flags and acknowledgement state; payload slots are not reset.
`timescale 1ns / 1ps
`default_nettype none
module selective_repeat_receiver_top
  import srr_pkg::*;
#(
  parameter int WINDOW       = 4,
  parameter int SEQ_BITS     = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input wire        clk,
  input wire        rst_n,
  srr_in_if.sink    in_pkt,
  srr_out_if.source out_res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DELIV = 2'd1;
  localparam logic [1:0] ST_ACK   = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [SEQ_BITS-1:0] base_r, base_nxt;
  logic                ack_made_r, ack_made_nxt;
  logic [SEQ_BITS-1:0] ack_val_r, ack_val_nxt;

  logic                    rcv [WINDOW+1];
  logic [PAYLOAD_BITS-1:0] pay [WINDOW+1];
  cell_ctrl_t              ctrl [WINDOW];
  logic [WINDOW-1:0]       wr_hit;

  logic [31:0]             seq_ext, fwd_ext, back_ext, ack_ext;
  logic [SEQ_BITS-1:0]     seq, fwd, back;
  logic [PAYLOAD_BITS-1:0] wr_data;
  logic                    in_acc, out_acc, in_win, in_back, shift;

  assign in_acc  = in_pkt.valid && in_pkt.ready;
  assign out_acc = out_res.valid && out_res.ready;

  assign seq_ext  = 32'(in_pkt.seq_num);
  assign seq      = seq_ext[SEQ_BITS-1:0];
  assign wr_data  = in_pkt.payload[PAYLOAD_BITS-1:0];
  assign fwd      = seq - base_r;
  assign back     = base_r - seq;
  assign fwd_ext  = 32'(fwd);
  assign back_ext = 32'(back);
  assign in_win   = in_pkt.checksum_ok && (fwd_ext < 32'(WINDOW));
  assign in_back  = in_pkt.checksum_ok && (back_ext >= 32'd1) && (back_ext <= 32'(WINDOW));
  assign shift    = (state_r == ST_DELIV) && out_res.ready;

  assign rcv[WINDOW] = 1'b0;
  assign pay[WINDOW] = '0;

  genvar i;
  generate
    for (i = 0; i < WINDOW; i++) begin : g_cell
      assign wr_hit[i]     = in_acc && in_win && (fwd_ext == 32'(i)) && !rcv[i];
      assign ctrl[i].wr    = wr_hit[i];
      assign ctrl[i].shift = shift;

      srr_cell #(
        .PAYLOAD_BITS(PAYLOAD_BITS)
      ) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl[i]),
        .wr_data(wr_data),
        .nb_rcv (rcv[i+1]),
        .nb_pay (pay[i+1]),
        .rcv    (rcv[i]),
        .pay    (pay[i])
      );
    end
  endgenerate

  always_comb begin
    state_nxt    = state_r;
    base_nxt     = base_r;
    ack_made_nxt = ack_made_r;
    ack_val_nxt  = ack_val_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = wr_hit[0] ? ST_DELIV : ST_ACK;
          if (in_win || in_back) begin
            ack_made_nxt = 1'b1;
            ack_val_nxt  = seq;
          end
        end
      end
      ST_DELIV: begin
        if (out_res.ready) begin
          base_nxt  = base_r + SEQ_BITS'(1);
          state_nxt = rcv[1] ? ST_DELIV : ST_ACK;
        end
      end
      ST_ACK: begin
        if (out_res.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      base_r     <= '0;
      ack_made_r <= 1'b0;
      ack_val_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      base_r     <= base_nxt;
      ack_made_r <= ack_made_nxt;
      ack_val_r  <= ack_val_nxt;
    end
  end

  assign ack_ext = 32'(ack_val_r);

  assign in_pkt.ready    = (state_r == ST_IDLE);
  assign out_res.valid   = (state_r == ST_DELIV) || (state_r == ST_ACK);
  assign out_res.kind    = (state_r == ST_ACK);
  assign out_res.last    = (state_r == ST_ACK);
  assign out_res.data    = (state_r == ST_DELIV) ? PAY_W'(pay[0]) : '0;
  assign out_res.ack_num = (state_r != ST_ACK) ? '0 :
                           ack_made_r ? $signed(ack_ext[ACK_W-1:0]) : $signed(ACK_NONE);

  // a delivered word always comes from a filled base slot
  a_deliv_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DELIV) |-> rcv[0])
    else $error("delivery from empty base slot");

  a_ack_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_res.last) |=> in_pkt.ready)
    else $error("not idle after acknowledgement");

  a_base_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !shift |=> $stable(base_r))
    else $error("window base moved without delivery");

  a_ack_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ack_made_r |=> ack_made_r)
    else $error("acknowledgement state lost");

endmodule
`default_nettype wire
